// ===== hw/rtl/vgb_pkg.sv =====
// Shared constants and types for the visibility grid binner.
// No dependencies; imported by every module of the block.
package vgb_pkg;

	localparam int GRID_SIZE  = 4096;
	localparam int BINS       = 16;
	localparam int SUPPORT    = 64;
	localparam int OVERSAMPLE = 8;
	localparam int W_PLANES   = 32;
	localparam int CHANNELS   = 4096;

	localparam int CHAN_W  = 12;
	localparam int COORD_W = 32;
	localparam int TAG_W   = 32;
	localparam int CFG_W   = 32;
	localparam int KIND_W  = 2;

	localparam int FRAC_BITS = 16;
	localparam int GRID_W    = $clog2(GRID_SIZE);
	localparam int BIN_W     = $clog2(BINS);
	localparam int OS_W      = $clog2(OVERSAMPLE);
	localparam int PLANE_W   = $clog2(W_PLANES);
	localparam int SPAN_W    = GRID_W + FRAC_BITS;
	localparam int REM_W     = SPAN_W - BIN_W;
	localparam int HALF_R    = (SUPPORT / 2) << FRAC_BITS;

	localparam int A_W   = 40;
	localparam int CS_W  = CHAN_W + CFG_W + 1;
	localparam int S_W   = 53;
	localparam int LANES = 3;

	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_GAIN     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_UV_OFFSET    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_W_SHIFT      = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_W_STEP_RECIP = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_CHAN_RATIO   = CFG_IDX_W'(4);

	localparam logic [CFG_W-1:0] RST_MAP_GAIN     = 32'd65536;
	localparam logic [CFG_W-1:0] RST_UV_OFFSET    = 32'd134217728;
	localparam logic [CFG_W-1:0] RST_W_SHIFT      = 32'd0;
	localparam logic [CFG_W-1:0] RST_W_STEP_RECIP = 32'd65536;
	localparam logic [CFG_W-1:0] RST_CHAN_RATIO   = 32'd0;

	localparam logic [KIND_W-1:0] KIND_HOME = 2'd0;
	localparam logic [KIND_W-1:0] KIND_U    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_V    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DIAG = 2'd3;

	typedef struct packed {
		logic [CFG_W-1:0] map_gain;
		logic [CFG_W-1:0] uv_offset;
		logic [CFG_W-1:0] w_shift;
		logic [CFG_W-1:0] w_step_recip;
		logic [CFG_W-1:0] chan_ratio;
	} vgb_cfg_t;

	typedef struct packed {
		logic [BIN_W-1:0]   bin_x;
		logic [BIN_W-1:0]   nbin_x;
		logic               near_u;
		logic [BIN_W-1:0]   bin_y;
		logic [BIN_W-1:0]   nbin_y;
		logic               near_v;
		logic [GRID_W-1:0]  cell_u;
		logic [GRID_W-1:0]  cell_v;
		logic [PLANE_W-1:0] w_plane;
		logic [OS_W-1:0]    frac_u;
		logic [OS_W-1:0]    frac_v;
		logic [CHAN_W-1:0]  chan;
		logic [TAG_W-1:0]   tag;
	} vgb_entry_t;

	typedef struct packed {
		logic [BIN_W-1:0]   bin_x;
		logic [BIN_W-1:0]   bin_y;
		logic [GRID_W-1:0]  cell_u;
		logic [GRID_W-1:0]  cell_v;
		logic [PLANE_W-1:0] w_plane;
		logic [OS_W-1:0]    frac_u;
		logic [OS_W-1:0]    frac_v;
		logic [CHAN_W-1:0]  chan_out;
		logic [TAG_W-1:0]   tag_out;
		logic [KIND_W-1:0]  copy_kind;
		logic               last;
	} vgb_result_t;

endpackage

// ===== hw/rtl/visibility_grid_binner.sv =====
// Visibility grid binner top level: configuration registers and block wiring.
// Depends on vgb_pkg, vgb_front, vgb_queue and vgb_back.
//
// Usage:
//   Input channel in_valid/in_stall takes one visibility per item: channel,
//   u, v, w (signed, 8 fraction bits) and a tag. Output channel
//   out_valid/out_stall gives one copy per item: home bin first, then the u
//   neighbor, the v neighbor and the diagonal when the point lies near bin
//   edges; last marks the final copy of a visibility.
//   The front is a 5-stage pipeline that takes one item every cycle while
//   in_stall is low; the output register sends one copy per cycle while
//   out_stall is low, and a visibility has 1, 2 or 4 copies.
//   An 8-entry queue sits between front and copy sequencer; in_stall rises
//   while 8 items are in the pipeline or queue.
//   When out_stall is high the output copy holds and the queue fills behind it.
//   Reset empties the pipeline and queue and loads the register defaults.
//   Registers are written through cfg_we/cfg_index/cfg_data; the user must
//   write them only while idle, as the block itself has no check for it.
module visibility_grid_binner (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic        [vgb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [vgb_pkg::CFG_W-1:0]      cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic        [vgb_pkg::CHAN_W-1:0]     chan_index,
	input  logic signed [vgb_pkg::COORD_W-1:0]    u_pos,
	input  logic signed [vgb_pkg::COORD_W-1:0]    v_pos,
	input  logic signed [vgb_pkg::COORD_W-1:0]    w_pos,
	input  logic        [vgb_pkg::TAG_W-1:0]      item_tag,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic        [vgb_pkg::BIN_W-1:0]      bin_x,
	output logic        [vgb_pkg::BIN_W-1:0]      bin_y,
	output logic        [vgb_pkg::GRID_W-1:0]     cell_u,
	output logic        [vgb_pkg::GRID_W-1:0]     cell_v,
	output logic        [vgb_pkg::PLANE_W-1:0]    w_plane,
	output logic        [vgb_pkg::OS_W-1:0]       frac_u,
	output logic        [vgb_pkg::OS_W-1:0]       frac_v,
	output logic        [vgb_pkg::CHAN_W-1:0]     chan_out,
	output logic        [vgb_pkg::TAG_W-1:0]      tag_out,
	output logic        [vgb_pkg::KIND_W-1:0]     copy_kind,
	output logic                                  last
);
	import vgb_pkg::*;

	vgb_cfg_t cfg_q;
	logic push, pop, q_not_empty;
	vgb_entry_t push_data, q_head;
	vgb_result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_gain     <= RST_MAP_GAIN;
			cfg_q.uv_offset    <= RST_UV_OFFSET;
			cfg_q.w_shift      <= RST_W_SHIFT;
			cfg_q.w_step_recip <= RST_W_STEP_RECIP;
			cfg_q.chan_ratio   <= RST_CHAN_RATIO;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAP_GAIN:     cfg_q.map_gain     <= cfg_data;
				REG_UV_OFFSET:    cfg_q.uv_offset    <= cfg_data;
				REG_W_SHIFT:      cfg_q.w_shift      <= cfg_data;
				REG_W_STEP_RECIP: cfg_q.w_step_recip <= cfg_data;
				REG_CHAN_RATIO:   cfg_q.chan_ratio   <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	vgb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.chan_index (chan_index),
		.u_pos      (u_pos),
		.v_pos      (v_pos),
		.w_pos      (w_pos),
		.item_tag   (item_tag),
		.pop        (pop),
		.push       (push),
		.push_data  (push_data)
	);

	vgb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (q_head),
		.not_empty (q_not_empty)
	);

	vgb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.not_empty (q_not_empty),
		.out_stall (out_stall),
		.pop       (pop),
		.res_valid (out_valid),
		.res       (res)
	);

	assign bin_x     = res.bin_x;
	assign bin_y     = res.bin_y;
	assign cell_u    = res.cell_u;
	assign cell_v    = res.cell_v;
	assign w_plane   = res.w_plane;
	assign frac_u    = res.frac_u;
	assign frac_v    = res.frac_v;
	assign chan_out  = res.chan_out;
	assign tag_out   = res.tag_out;
	assign copy_kind = res.copy_kind;
	assign last      = res.last;

`ifndef SYNTHESIS
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_not_empty)
		else $error("queue popped while empty");

	a_copies_together: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> (!out_valid || copy_kind != KIND_HOME))
		else $error("new item started before last copy of previous item");

	a_diag_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (copy_kind != KIND_DIAG || last))
		else $error("diagonal copy not marked last");
`endif

endmodule

// ===== hw/rtl/vgb_front.sv =====
// Front pipeline: grid map, channel scaling, bin and plane classification.
// Depends on vgb_pkg; feeds vgb_queue and tracks its free slots.
module vgb_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  vgb_pkg::vgb_cfg_t                    cfg,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic        [vgb_pkg::CHAN_W-1:0]    chan_index,
	input  logic signed [vgb_pkg::COORD_W-1:0]   u_pos,
	input  logic signed [vgb_pkg::COORD_W-1:0]   v_pos,
	input  logic signed [vgb_pkg::COORD_W-1:0]   w_pos,
	input  logic        [vgb_pkg::TAG_W-1:0]     item_tag,
	input  logic                                 pop,
	output logic                                 push,
	output vgb_pkg::vgb_entry_t                  push_data
);
	import vgb_pkg::*;

	localparam int MAP_W   = 2 * COORD_W + 1;
	localparam int LO_W    = 32;
	localparam int A_HI_W  = A_W - LO_W;
	localparam int CS_HI_W = CS_W - LO_W;
	localparam int UV_N    = 2;
	localparam int LANE_W  = 2;
	localparam int WLIM    = CFG_W + PLANE_W;
	localparam int WSUM_W  = WLIM + CFG_W;
	localparam int CHR_W   = CHAN_W + CFG_W;
	localparam int PP0_W   = 2 * LO_W;
	localparam int PP1_W   = LO_W + CS_HI_W;
	localparam int PP2_W   = A_HI_W + LO_W;
	localparam int PP3_W   = A_HI_W + CS_HI_W;
	localparam int WP0_W   = 2 * CFG_W;
	localparam logic [CHAN_W-1:0]  CH_MAX   = CHAN_W'(CHANNELS - 1);
	localparam logic [A_W-1:0]     A_LIM    = '1;
	localparam logic [QCNT_W-1:0]  QFULL    = QCNT_W'(QDEPTH);
	localparam logic [REM_W:0]     TOP_R    = (REM_W + 1)'(1) << REM_W;
	localparam logic [REM_W:0]     HALF_C   = (REM_W + 1)'(HALF_R);
	localparam logic [BIN_W-1:0]   BIN_LAST = BIN_W'(BINS - 1);

	logic accept;
	logic [QCNT_W-1:0] occ_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [CHAN_W-1:0] chan_s1, chan_s2, chan_s3, chan_s4, chan_s5;
	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic signed [COORD_W-1:0] coord [LANES];
	logic signed [MAP_W-1:0] prod_c [LANES];
	logic signed [MAP_W-1:0] prod_s1 [LANES];
	logic [CHAN_W-1:0] chan_sat;
	logic [CHAN_W+CFG_W-1:0] chr_c, chr_s1;

	logic signed [MAP_W-1:0] shift_c [LANES];
	logic signed [MAP_W-1:0] map_c [LANES];
	logic [A_W-1:0] a_c [LANES];
	logic [A_W-1:0] a_s2 [LANES];
	logic [CS_W-1:0] cs_c, cs_s2;

	logic [2*LO_W-1:0] pp0_s3 [LANES];
	logic [LO_W+CS_HI_W-1:0] pp1_s3 [LANES];
	logic [A_HI_W+LO_W-1:0] pp2_s3 [LANES];
	logic [A_HI_W+CS_HI_W-1:0] pp3_s3 [LANES];

	logic [S_W-1:0] s_c [LANES];
	logic [S_W-1:0] s_s4 [LANES];

	logic [SPAN_W-1:0] ssat [UV_N];
	logic [REM_W-1:0] rem [UV_N];
	logic [BIN_W-1:0] bin_c [UV_N];
	logic lower [UV_N];
	logic upper [UV_N];
	logic [BIN_W-1:0] bin_s5 [UV_N];
	logic [BIN_W-1:0] nbin_s5 [UV_N];
	logic near_s5 [UV_N];
	logic [GRID_W-1:0] cell_s5 [UV_N];
	logic [OS_W-1:0] frac_s5 [UV_N];
	logic [2*CFG_W-1:0] wp0_s5;
	logic [WLIM-1:0] wp1_s5;
	logic wbig_s5;

	logic [WSUM_W-1:0] wsum;
	logic [WLIM-1:0] plane_raw;
	logic plane_sat;

	assign in_stall = (occ_q >= QFULL);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({accept, pop})
				2'b10:   occ_q <= occ_q + QCNT_W'(1);
				2'b01:   occ_q <= occ_q - QCNT_W'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: grid map products and channel step
	always_comb begin
		coord[0] = u_pos;
		coord[1] = v_pos;
		coord[LANE_W] = w_pos;
		for (int l = 0; l < LANES; l++) begin
			prod_c[l] = MAP_W'(coord[l]) * MAP_W'($signed({1'b0, cfg.map_gain}));
		end
		chan_sat = (chan_index > CH_MAX) ? CH_MAX : chan_index;
		chr_c = CHR_W'(chan_sat) * CHR_W'(cfg.chan_ratio);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int l = 0; l < LANES; l++) begin
				prod_s1[l] <= prod_c[l];
			end
			chr_s1  <= chr_c;
			chan_s1 <= chan_index;
			tag_s1  <= item_tag;
		end
	end

	// stage 2: floor, offset, clamp to 40 bits
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (l == LANE_W) begin
				shift_c[l] = $signed({{(MAP_W-CFG_W){cfg.w_shift[CFG_W-1]}}, cfg.w_shift});
			end else begin
				shift_c[l] = $signed({{(MAP_W-CFG_W){1'b0}}, cfg.uv_offset});
			end
			map_c[l] = (prod_s1[l] >>> 8) + shift_c[l];
			if (map_c[l][MAP_W-1]) begin
				a_c[l] = '0;
			end else if (|map_c[l][MAP_W-2:A_W]) begin
				a_c[l] = A_LIM;
			end else begin
				a_c[l] = map_c[l][A_W-1:0];
			end
		end
		cs_c = CS_W'(chr_s1) + (CS_W'(1) << CFG_W);
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int l = 0; l < LANES; l++) begin
				a_s2[l] <= a_c[l];
			end
			cs_s2   <= cs_c;
			chan_s2 <= chan_s1;
			tag_s2  <= tag_s1;
		end
	end

	// stage 3: partial products of a * cs
	always_ff @(posedge clk) begin
		if (v_s2) begin
			for (int l = 0; l < LANES; l++) begin
				pp0_s3[l] <= PP0_W'(a_s2[l][LO_W-1:0]) * PP0_W'(cs_s2[LO_W-1:0]);
				pp1_s3[l] <= PP1_W'(a_s2[l][LO_W-1:0]) * PP1_W'(cs_s2[CS_W-1:LO_W]);
				pp2_s3[l] <= PP2_W'(a_s2[l][A_W-1:LO_W]) * PP2_W'(cs_s2[LO_W-1:0]);
				pp3_s3[l] <= PP3_W'(a_s2[l][A_W-1:LO_W]) * PP3_W'(cs_s2[CS_W-1:LO_W]);
			end
			chan_s3 <= chan_s2;
			tag_s3  <= tag_s2;
		end
	end

	// stage 4: sum partials, drop 32 fraction bits
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			s_c[l] = S_W'(pp0_s3[l][2*LO_W-1:LO_W]) + S_W'(pp1_s3[l]) + S_W'(pp2_s3[l])
				+ S_W'({pp3_s3[l], {LO_W{1'b0}}});
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			for (int l = 0; l < LANES; l++) begin
				s_s4[l] <= s_c[l];
			end
			chan_s4 <= chan_s3;
			tag_s4  <= tag_s3;
		end
	end

	// stage 5: cell, fraction, bin, margin side; w plane partials
	always_comb begin
		for (int l = 0; l < UV_N; l++) begin
			ssat[l] = (|s_s4[l][S_W-1:SPAN_W]) ? '1 : s_s4[l][SPAN_W-1:0];
			bin_c[l] = ssat[l][SPAN_W-1 -: BIN_W];
			rem[l] = ssat[l][REM_W-1:0];
			lower[l] = ({1'b0, rem[l]} < HALF_C) && (bin_c[l] != '0);
			upper[l] = !lower[l] && ((TOP_R - {1'b0, rem[l]}) < HALF_C)
				&& (bin_c[l] != BIN_LAST);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			for (int l = 0; l < UV_N; l++) begin
				bin_s5[l]  <= bin_c[l];
				nbin_s5[l] <= lower[l] ? bin_c[l] - BIN_W'(1) : bin_c[l] + BIN_W'(1);
				near_s5[l] <= lower[l] || upper[l];
				cell_s5[l] <= ssat[l][SPAN_W-1:FRAC_BITS];
				frac_s5[l] <= ssat[l][FRAC_BITS-1 -: OS_W];
			end
			wp0_s5  <= WP0_W'(s_s4[LANE_W][CFG_W-1:0]) * WP0_W'(cfg.w_step_recip);
			wp1_s5  <= WLIM'(s_s4[LANE_W][WLIM-1:CFG_W]) * WLIM'(cfg.w_step_recip);
			wbig_s5 <= |s_s4[LANE_W][S_W-1:WLIM];
			chan_s5 <= chan_s4;
			tag_s5  <= tag_s4;
		end
	end

	// plane sum and clamp, written into the queue
	always_comb begin
		wsum = {wp1_s5, {CFG_W{1'b0}}} + WSUM_W'(wp0_s5);
		plane_raw = wsum[WSUM_W-1:CFG_W];
		plane_sat = (wbig_s5 && (cfg.w_step_recip != '0)) || (|plane_raw[WLIM-1:PLANE_W]);
		push = v_s5;
		push_data.bin_x   = bin_s5[0];
		push_data.nbin_x  = nbin_s5[0];
		push_data.near_u  = near_s5[0];
		push_data.bin_y   = bin_s5[1];
		push_data.nbin_y  = nbin_s5[1];
		push_data.near_v  = near_s5[1];
		push_data.cell_u  = cell_s5[0];
		push_data.cell_v  = cell_s5[1];
		push_data.w_plane = plane_sat ? '1 : plane_raw[PLANE_W-1:0];
		push_data.frac_u  = frac_s5[0];
		push_data.frac_v  = frac_s5[1];
		push_data.chan    = chan_s5;
		push_data.tag     = tag_s5;
	end

endmodule

// ===== hw/rtl/vgb_queue.sv =====
// Short register queue between the front pipeline and the copy sequencer.
// Depends on vgb_pkg for the entry type and depth.
module vgb_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vgb_pkg::vgb_entry_t push_data,
	input  logic                pop,
	output vgb_pkg::vgb_entry_t head,
	output logic                not_empty
);
	import vgb_pkg::*;

	vgb_entry_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/vgb_back.sv =====
// Copy sequencer: emits home, neighbor and diagonal copies of each item.
// Depends on vgb_pkg; reads the head of vgb_queue, drives the output register.
module vgb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vgb_pkg::vgb_entry_t  head,
	input  logic                 not_empty,
	input  logic                 out_stall,
	output logic                 pop,
	output logic                 res_valid,
	output vgb_pkg::vgb_result_t res
);
	import vgb_pkg::*;

	logic [KIND_W-1:0] kind_q, kind_nxt;
	logic has_next;
	logic load;
	logic res_valid_q;
	vgb_result_t res_q;

	always_comb begin
		case (kind_q)
			KIND_HOME: begin
				has_next = head.near_u || head.near_v;
				kind_nxt = head.near_u ? KIND_U : KIND_V;
			end
			KIND_U: begin
				has_next = head.near_v;
				kind_nxt = KIND_V;
			end
			KIND_V: begin
				has_next = head.near_u;
				kind_nxt = KIND_DIAG;
			end
			default: begin
				has_next = 1'b0;
				kind_nxt = KIND_HOME;
			end
		endcase
	end

	assign load      = not_empty && (!res_valid_q || !out_stall);
	assign pop       = load && !has_next;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= KIND_HOME;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				kind_q      <= has_next ? kind_nxt : KIND_HOME;
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.bin_x     <= (kind_q == KIND_U || kind_q == KIND_DIAG) ? head.nbin_x : head.bin_x;
			res_q.bin_y     <= (kind_q == KIND_V || kind_q == KIND_DIAG) ? head.nbin_y : head.bin_y;
			res_q.cell_u    <= head.cell_u;
			res_q.cell_v    <= head.cell_v;
			res_q.w_plane   <= head.w_plane;
			res_q.frac_u    <= head.frac_u;
			res_q.frac_v    <= head.frac_v;
			res_q.chan_out  <= head.chan;
			res_q.tag_out   <= head.tag;
			res_q.copy_kind <= kind_q;
			res_q.last      <= !has_next;
		end
	end

endmodule

// ===== tb/sv/vgb_checker.sv =====
// Checker for the visibility grid binner: tracks register writes, predicts the
// bin copies of every accepted visibility and compares them with the output.
// Depends on vgb_pkg for widths, register indexes, copy kinds and result type.
module vgb_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic        [vgb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [vgb_pkg::CFG_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic        [vgb_pkg::CHAN_W-1:0]    chan_index,
	input  logic signed [vgb_pkg::COORD_W-1:0]   u_pos,
	input  logic signed [vgb_pkg::COORD_W-1:0]   v_pos,
	input  logic signed [vgb_pkg::COORD_W-1:0]   w_pos,
	input  logic        [vgb_pkg::TAG_W-1:0]     item_tag,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic        [vgb_pkg::BIN_W-1:0]     bin_x,
	input  logic        [vgb_pkg::BIN_W-1:0]     bin_y,
	input  logic        [vgb_pkg::GRID_W-1:0]    cell_u,
	input  logic        [vgb_pkg::GRID_W-1:0]    cell_v,
	input  logic        [vgb_pkg::PLANE_W-1:0]   w_plane,
	input  logic        [vgb_pkg::OS_W-1:0]      frac_u,
	input  logic        [vgb_pkg::OS_W-1:0]      frac_v,
	input  logic        [vgb_pkg::CHAN_W-1:0]    chan_out,
	input  logic        [vgb_pkg::TAG_W-1:0]     tag_out,
	input  logic        [vgb_pkg::KIND_W-1:0]    copy_kind,
	input  logic                                 last,
	output int                                   fail_count,
	output int                                   copies_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import vgb_pkg::*;

	localparam longint SPAN   = longint'(GRID_SIZE) << FRAC_BITS;
	localparam longint MARGIN = longint'(SUPPORT) * BINS * 32768;
	localparam longint A_LIM  = (longint'(1) << A_W) - 1;

	typedef struct {
		logic [GRID_W-1:0] cell_idx;
		logic [OS_W-1:0]   frac;
		logic [BIN_W-1:0]  bin;
		logic [BIN_W-1:0]  nbr;
		logic              near;
	} axis_pos_t;

	vgb_cfg_t    regs;
	vgb_result_t copies_due[$];
	vgb_result_t want;
	int          err_cnt = 0;

	function automatic logic [A_W-1:0] map_coord(logic signed [31:0] p,
			logic signed [32:0] off);
		logic signed [65:0] prod;
		logic signed [66:0] sum;
		prod = p * $signed({1'b0, regs.map_gain});
		sum = (prod >>> 8) + off;
		if (sum < 0)
			return '0;
		if (sum > A_LIM)
			return '1;
		return sum[A_W-1:0];
	endfunction

	function automatic logic [S_W-1:0] chan_scale(logic [A_W-1:0] a, logic [CHAN_W-1:0] ch);
		logic [44:0] cs;
		logic [84:0] prod;
		cs = (45'd1 << 32) + ch * regs.chan_ratio;
		prod = a * cs;
		return prod[84:32];
	endfunction

	function automatic axis_pos_t locate(logic [S_W-1:0] s_in);
		longint    s;
		longint    t;
		longint    bin;
		longint    rem;
		axis_pos_t r;
		s = longint'(s_in);
		if (s >= SPAN)
			s = SPAN - 1;
		r.cell_idx = s >> FRAC_BITS;
		r.frac = ((s & 64'hFFFF) * OVERSAMPLE) >> FRAC_BITS;
		t = s * BINS;
		bin = t / SPAN;
		rem = t - bin * SPAN;
		r.bin = bin;
		r.nbr = bin;
		r.near = 1'b0;
		if (rem < MARGIN && bin >= 1) begin
			r.near = 1'b1;
			r.nbr = bin - 1;
		end else if (SPAN - rem < MARGIN && bin + 1 < BINS) begin
			r.near = 1'b1;
			r.nbr = bin + 1;
		end
		return r;
	endfunction

	task automatic predict_copies(logic [CHAN_W-1:0] ch_in, logic signed [31:0] u,
			logic signed [31:0] v, logic signed [31:0] w, logic [TAG_W-1:0] tag);
		logic [CHAN_W-1:0]  ch;
		logic [S_W-1:0]     su;
		logic [S_W-1:0]     sv;
		logic [S_W-1:0]     sw;
		logic [84:0]        wprod;
		logic [S_W-1:0]     plane_q;
		axis_pos_t          au;
		axis_pos_t          av;
		vgb_result_t        c;
		ch = ch_in;
		if (ch > CHANNELS - 1)
			ch = CHANNELS - 1;
		su = chan_scale(map_coord(u, {1'b0, regs.uv_offset}), ch);
		sv = chan_scale(map_coord(v, {1'b0, regs.uv_offset}), ch);
		sw = chan_scale(map_coord(w, {regs.w_shift[CFG_W-1], regs.w_shift}), ch);
		wprod = sw * regs.w_step_recip;
		plane_q = wprod[84:32];
		au = locate(su);
		av = locate(sv);
		c.cell_u = au.cell_idx;
		c.cell_v = av.cell_idx;
		c.frac_u = au.frac;
		c.frac_v = av.frac;
		c.w_plane = (plane_q > W_PLANES - 1) ? PLANE_W'(W_PLANES - 1) : plane_q[PLANE_W-1:0];
		c.chan_out = ch_in;
		c.tag_out = tag;
		c.bin_x = au.bin;
		c.bin_y = av.bin;
		c.copy_kind = KIND_HOME;
		c.last = !(au.near || av.near);
		copies_due.push_back(c);
		if (au.near) begin
			c.bin_x = au.nbr;
			c.bin_y = av.bin;
			c.copy_kind = KIND_U;
			c.last = !av.near;
			copies_due.push_back(c);
		end
		if (av.near) begin
			c.bin_x = au.bin;
			c.bin_y = av.nbr;
			c.copy_kind = KIND_V;
			c.last = !au.near;
			copies_due.push_back(c);
		end
		if (au.near && av.near) begin
			c.bin_x = au.nbr;
			c.bin_y = av.nbr;
			c.copy_kind = KIND_DIAG;
			c.last = 1'b1;
			copies_due.push_back(c);
		end
	endtask

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got);
		if (exp_val !== got) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_val, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			regs = {RST_MAP_GAIN, RST_UV_OFFSET, RST_W_SHIFT, RST_W_STEP_RECIP,
				RST_CHAN_RATIO};
			copies_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (copies_due.size() == 0) begin
					$display("%0t unexpected copy: expected none actual tag %0h kind %0d",
						$time, tag_out, copy_kind);
					err_cnt++;
				end else begin
					want = copies_due.pop_front();
					check_field("bin_x", want.bin_x, bin_x);
					check_field("bin_y", want.bin_y, bin_y);
					check_field("cell_u", want.cell_u, cell_u);
					check_field("cell_v", want.cell_v, cell_v);
					check_field("w_plane", want.w_plane, w_plane);
					check_field("frac_u", want.frac_u, frac_u);
					check_field("frac_v", want.frac_v, frac_v);
					check_field("chan_out", want.chan_out, chan_out);
					check_field("tag_out", want.tag_out, tag_out);
					check_field("copy_kind", want.copy_kind, copy_kind);
					check_field("last", want.last, last);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MAP_GAIN:     regs.map_gain = cfg_data;
					REG_UV_OFFSET:    regs.uv_offset = cfg_data;
					REG_W_SHIFT:      regs.w_shift = cfg_data;
					REG_W_STEP_RECIP: regs.w_step_recip = cfg_data;
					REG_CHAN_RATIO:   regs.chan_ratio = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_copies(chan_index, u_pos, v_pos, w_pos, item_tag);
		end
		fail_count <= err_cnt;
		copies_pending <= copies_due.size();
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the visibility grid binner bench: clock, reset, register programming,
// directed and random visibilities, output stalls and the verdict.
// Depends on vgb_pkg, visibility_grid_binner and vgb_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vgb_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int TAIL_CYCLES  = 20;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic        [CFG_IDX_W-1:0] cfg_index = '0;
	logic        [CFG_W-1:0]     cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic        [CHAN_W-1:0]    chan_index = '0;
	logic signed [COORD_W-1:0]   u_pos = '0;
	logic signed [COORD_W-1:0]   v_pos = '0;
	logic signed [COORD_W-1:0]   w_pos = '0;
	logic        [TAG_W-1:0]     item_tag = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic        [BIN_W-1:0]     bin_x;
	logic        [BIN_W-1:0]     bin_y;
	logic        [GRID_W-1:0]    cell_u;
	logic        [GRID_W-1:0]    cell_v;
	logic        [PLANE_W-1:0]   w_plane;
	logic        [OS_W-1:0]      frac_u;
	logic        [OS_W-1:0]      frac_v;
	logic        [CHAN_W-1:0]    chan_out;
	logic        [TAG_W-1:0]     tag_out;
	logic        [KIND_W-1:0]    copy_kind;
	logic                       last;
	int                         fail_count;
	int                         copies_pending;

	logic calm = 1'b0;
	int   hold_left = 0;
	int   cycles = 0;

	visibility_grid_binner u_dut (.*);

	vgb_checker u_chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("[visibility_grid_binner] ERROR");
			$finish;
		end
	end

	function automatic int pause_len();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 14)
			return $urandom_range(1, 2);
		if (sel < 19)
			return $urandom_range(3, 8);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			hold_left <= pause_len() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send(logic [CHAN_W-1:0] ch, logic signed [31:0] u, logic signed [31:0] v,
			logic signed [31:0] w, logic [TAG_W-1:0] tag);
		int gap;
		in_valid <= 1'b1;
		chan_index <= ch;
		u_pos <= u;
		v_pos <= v;
		w_pos <= w;
		item_tag <= tag;
		do
			@(posedge clk);
		while (in_stall);
		gap = (calm || $urandom_range(0, 1)) ? 0 : pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (copies_pending != 0);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_regs(logic [CFG_W-1:0] scale, logic [CFG_W-1:0] uv_off,
			logic [CFG_W-1:0] w_off, logic [CFG_W-1:0] recip, logic [CFG_W-1:0] ratio);
		drain();
		set_reg(REG_MAP_GAIN, scale);
		set_reg(REG_UV_OFFSET, uv_off);
		set_reg(REG_W_SHIFT, w_off);
		set_reg(REG_W_STEP_RECIP, recip);
		set_reg(REG_CHAN_RATIO, ratio);
	endtask

	function automatic logic signed [31:0] pick_uv();
		int sel;
		int edge_cell;
		int d;
		sel = $urandom_range(0, 9);
		if (sel < 2)
			return $urandom;
		if (sel < 5)
			return (int'($urandom_range(0, 4095)) - 2048) * 256 + int'($urandom_range(0, 255));
		edge_cell = $urandom_range(0, BINS) * (GRID_SIZE / BINS);
		d = int'($urandom_range(0, 79)) - 40;
		return (edge_cell - 2048 + d) * 256 + int'($urandom_range(0, 255));
	endfunction

	function automatic logic signed [31:0] pick_w();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return (int'($urandom_range(0, 40)) - 4) * 256 + int'($urandom_range(0, 255));
	endfunction

	task automatic random_items(int count, int pause_at);
		logic [CHAN_W-1:0] ch;
		for (int k = 0; k < count; k++) begin
			calm <= ((k / 8) % 4 == 1);
			ch = $urandom_range(0, 1) ? CHAN_W'($urandom_range(0, 4095))
				: CHAN_W'($urandom_range(0, 7));
			send(ch, pick_uv(), pick_uv(), pick_w(), $urandom);
			if (k == pause_at)
				drain();
		end
		calm <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: unit scale, grid centered, one plane per cell
		send(12'd0, 32'sd0, 32'sd0, 32'sd0, 32'h0000_0000);
		send(12'd4095, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
		send(12'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0002);
		send(12'd2, 246 * 256, 100 * 256, 5 * 256, 32'h0000_0003);
		send(12'd3, 100 * 256, 8191, 7 * 256, 32'h0000_0004);
		send(12'd4, 8192, 57344, 9 * 256, 32'h0000_0005);
		send(12'd5, 57345, -1, -1, 32'h0000_0006);
		send(12'd6, -523008, 522752, 31 * 256 + 255, 32'h0000_0007);
		send(12'd7, 255, 32, 32 * 256, 32'h0000_0008);
		send(12'd8, -2048 * 256, 2048 * 256 - 1, 0, 32'h0000_0009);
		send(12'd9, 2048 * 256, -2048 * 256 - 1, 255, 32'h0000_000A);
		send(12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		send(12'h555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
		random_items(30, 12);

		// largest scale and channel ratio, no offsets, zero plane step reciprocal, lowest w offset
		load_regs(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
		send(12'd4095, 1, -1, 0, 32'h0000_0101);
		send(12'd0, 0, 0, 32'h7FFF_FFFF, 32'h0000_0102);
		send(12'd0, 1, 2, 3, 32'h0000_0103);
		random_items(15, -1);

		// zero scale, largest offsets and plane step reciprocal
		load_regs(32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		send(12'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0201);
		send(12'd4095, 0, 0, 0, 32'h0000_0202);
		random_items(15, -1);

		for (int p = 0; p < 2; p++) begin
			load_regs(32'(65536 - 4096 + $urandom_range(0, 8192)),
				32'((2048 << 16) - (1 << 20) + $urandom_range(0, 1 << 21)),
				32'(int'($urandom_range(0, 16 << 16)) - (8 << 16)),
				32'($urandom_range(1 << 14, 1 << 18)),
				(p == 0) ? 32'($urandom_range(0, 1 << 20)) : 32'($urandom_range(0, 1 << 26)));
			random_items(21, -1);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && copies_pending == 0)
			$display("[visibility_grid_binner] OK");
		else
			$display("[visibility_grid_binner] ERROR");
		$finish;
	end

endmodule
